/* sv/cfba_pkg.sv */
`timescale 1ns / 1ps

package cfba_pkg;

  localparam int BLK_W     = 10;
  localparam int BC_W      = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [BLK_W-1:0] DATA_START_RST  = 10'd1;
  localparam logic [BC_W-1:0]  BLOCK_COUNT_RST = 11'd1024;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } cfba_status_t;

  typedef struct packed {
    logic             mode;
    logic [BLK_W-1:0] block_number;
  } cfba_in_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic [1:0]       status;
  } cfba_out_t;

  // controller -> datapath
  typedef struct packed {
    logic         load_req;
    logic         pop;
    logic         take_blk;
    logic         nospace;
    logic         idx_clr;
    logic         rld_step;
    logic         spl_step;
    logic         push;
    logic         out_load;
    logic         out_grant;
    cfba_status_t out_status;
  } cfba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic count_over;
    logic count_full;
    logic blk_zero;
    logic blk_valid;
    logic req_valid;
    logic idx_done;
  } cfba_sts_t;

endpackage

/* sv/cfba_ram.sv */
`timescale 1ns / 1ps

module cfba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/cfba_ctrl.sv */
`timescale 1ns / 1ps

module cfba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  cfba_pkg::cfba_sts_t sts,
  output cfba_pkg::cfba_cmd_t cmd
);
  import cfba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_EVAL,
    S_RELOAD,
    S_FREE_CHK,
    S_SPILL,
    S_DONE
  } state_t;

  state_t       state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  cfba_status_t res_r, res_nxt;
  logic         grant_r, grant_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    grant_nxt = grant_r;
    cmd       = '0;
    cmd.out_grant  = grant_r;
    cmd.out_status = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt = (in_mode == MODE_FREE) ? S_FREE_CHK : S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        if (sts.count_zero || sts.count_over) begin
          cmd.nospace = 1'b1;
          res_nxt   = ST_NOSPACE;
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_ALLOC_EVAL;
        end
      end
      S_ALLOC_EVAL: begin
        cmd.take_blk = 1'b1;
        if (sts.blk_zero) begin
          cmd.nospace = 1'b1;
          res_nxt   = ST_NOSPACE;
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (!sts.blk_valid) begin
          state_nxt = S_ALLOC_CHK;  // out-of-range id: drop it, pop again
        end else if (sts.count_zero) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_RELOAD;
        end else begin
          res_nxt   = ST_OK;
          grant_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RELOAD: begin
        cmd.rld_step = 1'b1;
        if (sts.idx_done) begin
          if (sts.count_zero) begin
            cmd.nospace = 1'b1;
            res_nxt   = ST_NOSPACE;
            grant_nxt = 1'b0;
          end else begin
            res_nxt   = ST_OK;
            grant_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (!sts.req_valid) begin
          res_nxt   = ST_BADFREE;
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (sts.count_full) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SPILL;
        end else begin
          cmd.push  = 1'b1;
          res_nxt   = ST_OK;
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_SPILL: begin
        cmd.spl_step = 1'b1;
        if (sts.idx_done) begin
          cmd.push  = 1'b1;  // lands in entry 0 of the now empty cache
          res_nxt   = ST_OK;
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      res_r       <= ST_OK;
      grant_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      grant_r     <= grant_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ALLOC_CHK || state_r == S_FREE_CHK))
    else $error("accepted item did not start work");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_badfree_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r == ST_BADFREE) |-> !grant_r)
    else $error("rejected free carries a block id");

  a_reload_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELOAD && !sts.idx_done) |=> state_r == S_RELOAD)
    else $error("reload cut short");
`endif

endmodule

/* sv/cfba_dpath.sv */
`timescale 1ns / 1ps

module cfba_dpath #(
  parameter int CACHE_DEPTH = 16,
  parameter int NUM_BLOCKS  = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cfba_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [cfba_pkg::CFG_W-1:0]          cfg_wdata,
  input  cfba_pkg::cfba_in_t                  in_data,
  input  cfba_pkg::cfba_cmd_t                 cmd,
  output cfba_pkg::cfba_sts_t                 sts,
  output cfba_pkg::cfba_out_t                 out_data
);
  import cfba_pkg::*;

  localparam int CNT_W      = $clog2(CACHE_DEPTH + 1);
  localparam int CA_W       = $clog2(CACHE_DEPTH);
  localparam int CHAIN_BLKS = (NUM_BLOCKS < (1 << BLK_W)) ? NUM_BLOCKS : (1 << BLK_W);
  localparam int CB_W       = $clog2(CHAIN_BLKS);
  localparam int CL_DEPTH   = CHAIN_BLKS * CACHE_DEPTH;
  localparam int CL_AW      = $clog2(CL_DEPTH);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(CACHE_DEPTH);
  localparam logic [CL_AW-1:0] DEPTH_A = CL_AW'(CACHE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [BLK_W-1:0] data_start_r;
  logic [BC_W-1:0]  block_count_r;
  cfba_in_t         req_r;
  logic [BLK_W-1:0] blk_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             zero_ok_r, zero_ok_nxt;
  logic [CNT_W-1:0] idx_r;
  logic             rd0_r;
  cfba_out_t        out_r;

  logic [CNT_W-1:0] cnt_eff, cnt_m1, idx_m1;
  logic             cnt_full;

  logic             c_we;
  logic [CA_W-1:0]  c_waddr, c_raddr;
  logic [BLK_W-1:0] c_wdata, c_q, cache_rd;

  logic             cc_we;
  logic [CNT_W-1:0] cc_q;

  logic             cl_we;
  logic [CL_AW-1:0] cl_waddr, cl_raddr;
  logic [BLK_W-1:0] cl_q;

  function automatic logic id_ok(input logic [BLK_W-1:0] id,
                                 input logic [BLK_W-1:0] ds,
                                 input logic [BC_W-1:0]  bc);
    logic lim;
    lim = ({{(32-BLK_W){1'b0}}, id} < 32'(NUM_BLOCKS));
    return lim && (id >= ds) && ({1'b0, id} < bc);
  endfunction

  // Entry zero reads as the sentinel until something is written there.
  assign cache_rd = (rd0_r && !zero_ok_r) ? '0 : c_q;

  assign cnt_eff  = (cnt_r == '0) ? ONE_C : cnt_r;
  assign cnt_m1   = cnt_r - ONE_C;
  assign idx_m1   = idx_r - ONE_C;
  assign cnt_full = (cnt_eff >= DEPTH_C);

  // cache port
  assign c_raddr = cmd.pop ? CA_W'(cnt_m1) : CA_W'(idx_r);

  always_comb begin
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = req_r.block_number;
    if (cmd.rld_step && idx_r != '0) begin
      c_we    = 1'b1;
      c_waddr = CA_W'(idx_m1);
      c_wdata = cl_q;
    end else if (cmd.push) begin
      c_we    = 1'b1;
      c_waddr = cnt_full ? '0 : CA_W'(cnt_eff);
    end
  end

  // chain records: spill writes under the freed block, reload reads under the popped one
  assign cc_we    = cmd.spl_step && (idx_r == '0);
  assign cl_we    = cmd.spl_step && (idx_r != '0);
  assign cl_waddr = CL_AW'(req_r.block_number[CB_W-1:0]) * DEPTH_A + CL_AW'(idx_m1);
  assign cl_raddr = CL_AW'(blk_r[CB_W-1:0]) * DEPTH_A + CL_AW'(idx_r);

  cfba_ram #(.WIDTH(BLK_W), .DEPTH(CACHE_DEPTH)) u_cache (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_q)
  );

  cfba_ram #(.WIDTH(CNT_W), .DEPTH(CHAIN_BLKS)) u_chain_cnt (
    .clk   (clk),
    .we    (cc_we),
    .waddr (req_r.block_number[CB_W-1:0]),
    .wdata (cnt_r),
    .raddr (blk_r[CB_W-1:0]),
    .rdata (cc_q)
  );

  cfba_ram #(.WIDTH(BLK_W), .DEPTH(CL_DEPTH)) u_chain_list (
    .clk   (clk),
    .we    (cl_we),
    .waddr (cl_waddr),
    .wdata (cache_rd),
    .raddr (cl_raddr),
    .rdata (cl_q)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.nospace) begin
      cnt_nxt = '0;
    end else if (cmd.pop) begin
      cnt_nxt = cnt_m1;
    end else if (cmd.rld_step && idx_r == ONE_C) begin
      cnt_nxt = cc_q;
    end else if (cmd.push) begin
      cnt_nxt = cnt_full ? ONE_C : cnt_eff + ONE_C;
    end

    zero_ok_nxt = zero_ok_r;
    if (c_we && c_waddr == '0) begin
      zero_ok_nxt = 1'b1;
    end else if (cmd.push && cnt_r == '0) begin
      zero_ok_nxt = 1'b0;  // free into empty cache: entry 0 becomes the sentinel
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r  <= DATA_START_RST;
      block_count_r <= BLOCK_COUNT_RST;
      cnt_r         <= ONE_C;
      zero_ok_r     <= 1'b0;
      idx_r         <= '0;
    end else begin
      if (cfg_we && cfg_addr == REG_DATA_START) begin
        data_start_r <= cfg_wdata[BLK_W-1:0];
      end
      if (cfg_we && cfg_addr == REG_BLOCK_COUNT) begin
        block_count_r <= cfg_wdata[BC_W-1:0];
      end
      cnt_r     <= cnt_nxt;
      zero_ok_r <= zero_ok_nxt;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if ((cmd.rld_step || cmd.spl_step) && idx_r != DEPTH_C) begin
        idx_r <= idx_r + ONE_C;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd0_r <= (c_raddr == '0);
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.take_blk) begin
      blk_r <= cache_rd;
    end
    if (cmd.out_load) begin
      out_r.granted_block <= cmd.out_grant ? blk_r : '0;
      out_r.status        <= cmd.out_status;
    end
  end

  always_comb begin
    sts.count_zero = (cnt_r == '0);
    sts.count_over = (cnt_r > DEPTH_C);
    sts.count_full = cnt_full;
    sts.blk_zero   = (cache_rd == '0);
    sts.blk_valid  = id_ok(cache_rd, data_start_r, block_count_r);
    sts.req_valid  = id_ok(req_r.block_number, data_start_r, block_count_r);
    sts.idx_done   = (idx_r == DEPTH_C);
  end

  assign out_data = out_r;

endmodule

/* sv/chained_free_block_allocator.sv */
`timescale 1ns / 1ps
// Block allocator over a chained free list with an in-core cache of free ids.
// Input channel (in_valid / in_stall / in_data): mode 0 allocates a block,
//   mode 1 frees in_data.block_number. One item is worked at a time; in_stall
//   is high from acceptance until the result is placed in the output register.
// Result channel (out_valid / out_stall / out_data): one result per item,
//   granted_block and status (ok, no space, free rejected).
// Steps per item: a granted allocate checks the cache count, pops an id and
//   evaluates it before its result. A free, a rejected free or an allocate
//   that finds the cache empty goes from its check straight to the result.
//   Each skipped out-of-range id adds another pop (one cache read per pop).
//   A reload when the cache empties, or a spill when a free finds it full,
//   copies the cache through the chain record RAM one entry a cycle.
// Stall: the finished result sits in the output register; the next item may
//   be accepted and worked meanwhile, and waits before its own result if the
//   register is still held.
// Reset (rst_n, synchronous): cache holds one entry, the sentinel 0;
//   data_start = 1, block_count = 1024. No clearing pass; chain records are
//   defined only once written by a spill. Config writes via cfg_we/cfg_addr.

module chained_free_block_allocator #(
  parameter int CACHE_DEPTH = 16,
  parameter int NUM_BLOCKS  = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cfba_pkg::cfba_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cfba_pkg::cfba_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [cfba_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cfba_pkg::CFG_W-1:0]     cfg_wdata
);
  import cfba_pkg::*;

  cfba_cmd_t cmd;
  cfba_sts_t sts;

  cfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfba_dpath #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

/* test/chained_free_block_allocator_test.sv */
`timescale 1ns / 1ps

module chained_free_block_allocator_test;
  import cfba_pkg::*;

  localparam int DEPTH       = 16;
  localparam int NBLK        = 1024;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 60;

  // Tracks the free list and the replies it should produce.
  class free_list_scoreboard;
    int unsigned      data_start;
    int unsigned      block_count;
    int unsigned      cache_count;
    logic [BLK_W-1:0] cache_ids [DEPTH];
    int unsigned      chain_cnt [NBLK];
    logic [BLK_W-1:0] chain_ids [NBLK*DEPTH];
    cfba_out_t        pending_replies [$];
    int mismatches, frees, allocs, spills, reloads, skips, nospace_cnt, rejects;

    function new();
      data_start  = DATA_START_RST;
      block_count = BLOCK_COUNT_RST;
      cache_count = 1;
      foreach (cache_ids[i]) cache_ids[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_DATA_START) begin
        data_start = val[BLK_W-1:0];
      end else begin
        block_count = val;
      end
    endfunction

    function bit in_range(logic [BLK_W-1:0] id);
      return id >= data_start && id < block_count;
    endfunction

    function void note_request(cfba_in_t req);
      cfba_out_t        reply;
      logic [BLK_W-1:0] id;
      bit               done;
      int unsigned      base;
      reply.granted_block = '0;
      if (req.mode == MODE_FREE) begin
        frees++;
        reply.status = ST_BADFREE;
        if (in_range(req.block_number)) begin
          if (cache_count == 0) begin
            cache_count  = 1;
            cache_ids[0] = '0;
          end
          // full cache moves into the chain record of the freed block
          if (cache_count >= DEPTH) begin
            base = req.block_number * DEPTH;
            chain_cnt[req.block_number] = cache_count;
            for (int i = 0; i < DEPTH; i++) chain_ids[base + i] = cache_ids[i];
            cache_count = 0;
            spills++;
          end
          cache_ids[cache_count] = req.block_number;
          cache_count++;
          reply.status = ST_OK;
        end else begin
          rejects++;
        end
      end else begin
        allocs++;
        reply.status = ST_NOSPACE;
        done = 1'b0;
        while (!done) begin
          if (cache_count == 0 || cache_count > DEPTH) begin
            done = 1'b1;
          end else begin
            cache_count--;
            id = cache_ids[cache_count];
            if (id == '0) begin
              done = 1'b1;
            end else if (in_range(id)) begin
              done = 1'b1;
              if (cache_count == 0) begin
                base        = id * DEPTH;
                cache_count = chain_cnt[id];
                for (int i = 0; i < DEPTH; i++) cache_ids[i] = chain_ids[base + i];
                reloads++;
              end
              if (cache_count != 0) begin
                reply.granted_block = id;
                reply.status        = ST_OK;
              end
            end else begin
              skips++;
            end
          end
        end
        if (reply.status == ST_NOSPACE) begin
          cache_count = 0;
          nospace_cnt++;
        end
      end
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(cfba_out_t got);
      cfba_out_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected reply: block %0d status %0d", got.granted_block, got.status);
        return;
      end
      want = pending_replies.pop_front();
      if (got.granted_block !== want.granted_block || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected block %0d status %0d, got block %0d status %0d",
                   want.granted_block, want.status, got.granted_block, got.status);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cfba_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  cfba_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  bit sender_gaps;
  bit receiver_busy;
  bit hold_request;
  bit hold_phase;
  int idle_cycles = 0;

  free_list_scoreboard sb = new();

  chained_free_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_reply(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (receiver_busy && $urandom_range(99) < 25) begin
        out_stall  <= 1'b1;
        stall_left = gap_length() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_request(input logic mode, input logic [BLK_W-1:0] blk);
    int gap;
    in_data  <= cfba_in_t'{mode, blk};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    gap = (sender_gaps && $urandom_range(99) < 35) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input int ds, input int bc);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DATA_START;
    cfg_wdata <= CFG_W'(ds);
    sb.write_reg(REG_DATA_START, CFG_W'(ds));
    @(negedge clk);
    cfg_addr  <= REG_BLOCK_COUNT;
    cfg_wdata <= CFG_W'(bc);
    sb.write_reg(REG_BLOCK_COUNT, CFG_W'(bc));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // free-heavy first half builds the chain, alloc-heavy second half drains it
  task automatic run_phase(input int ds, input int bc);
    int   free_hi, free_lo, pct;
    logic mode;
    logic [BLK_W-1:0] blk;
    settle();
    set_config(ds, bc);
    // long receiver hold starts once items are flowing again
    if (hold_phase) begin
      hold_phase   = 1'b0;
      hold_request = 1'b1;
    end
    free_hi = $urandom_range(90, 60);
    free_lo = $urandom_range(40, 10);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pct  = (i < PHASE_ITEMS / 2) ? free_hi : free_lo;
      mode = ($urandom_range(99) < pct) ? MODE_FREE : MODE_ALLOC;
      if (ds < bc && $urandom_range(99) < 80) begin
        blk = BLK_W'($urandom_range(bc - 1, ds));
      end else begin
        blk = BLK_W'($urandom_range(NBLK - 1, 0));
      end
      send_request(mode, blk);
    end
  endtask

  initial begin
    int ds, bc;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    sender_gaps   = 1'b1;
    receiver_busy = 1'b1;
    hold_request  = 1'b0;
    hold_phase    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: sentinel, empty cache, reject, spill, reload, skips
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '1);
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, 10'd1023);
    for (int b = 2; b <= 15; b++) send_request(MODE_FREE, BLK_W'(b));
    send_request(MODE_FREE, 10'd16);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    settle();
    set_config(14, 1024);
    repeat (3) send_request(MODE_ALLOC, '0);

    for (int p = 0; p < 12; p++) begin
      sender_gaps   = (p % 3 != 1);
      receiver_busy = (p % 4 != 2);
      case (p)
        0: begin
          ds = 0;
          bc = 1024;
        end
        1: begin
          ds = 1023;
          bc = 1024;
        end
        2: begin
          ds = 0;
          bc = 1;
        end
        3: begin
          ds = 512;
          bc = 300;
        end
        4: begin
          ds = 1;
          bc = 1024;
        end
        default: begin
          ds = $urandom_range(300, 0);
          bc = ($urandom_range(3) == 0) ? $urandom_range(1024, 1)
                                        : $urandom_range(1024, ds + 20);
        end
      endcase
      if (p == 0) begin
        // hold results long enough that the block backs up into the input
        sender_gaps = 1'b0;
        hold_phase  = 1'b1;
      end
      run_phase(ds, bc);
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Covered %0d frees (%0d rejected) and %0d allocs (%0d no space)",
             sb.frees, sb.rejects, sb.allocs, sb.nospace_cnt);
    $display("Cache spills %0d, reloads %0d, skipped ids %0d, mismatches %0d",
             sb.spills, sb.reloads, sb.skips, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
